### rtl/xtss_pkg.sv
package xtss_pkg;

    // result kinds
    typedef enum logic [3:0] {
        KIND_TEXT   = 4'd0,
        KIND_NAME   = 4'd1,
        KIND_STRING = 4'd2,
        KIND_INT    = 4'd3,
        KIND_GUID   = 4'd4,
        KIND_INTS   = 4'd5,
        KIND_FLTS   = 4'd6,
        KIND_KEY    = 4'd7,
        KIND_UNK    = 4'd8,
        KIND_TRUNC  = 4'd9
    } t_kind;

    // input transfer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_end;
    } t_in_item;

    // output transfer
    typedef struct packed {
        t_kind      kind;
        logic [7:0] token_byte;
        logic       token_end;
        logic       token_empty;
    } t_out_item;

    // register map (index taken from paddr[2])
    localparam int  PADDR_W         = 3;
    localparam logic REG_BINARY_MODE = 1'b0;
    localparam logic REG_FLOAT_BYTES = 1'b1;
    localparam logic [3:0] FLOAT_BYTES_RST = 4'd4;

    // binary token ids
    localparam logic [15:0] ID_NAME    = 16'h0001;
    localparam logic [15:0] ID_STRING  = 16'h0002;
    localparam logic [15:0] ID_INT     = 16'h0003;
    localparam logic [15:0] ID_GUID    = 16'h0005;
    localparam logic [15:0] ID_INTLIST = 16'h0006;
    localparam logic [15:0] ID_FLTLIST = 16'h0007;

    // keyword id ranges
    localparam logic [15:0] KEY_LO_A = 16'h000a;
    localparam logic [15:0] KEY_HI_A = 16'h0014;
    localparam logic [15:0] KEY_MID  = 16'h001f;
    localparam logic [15:0] KEY_LO_B = 16'h0028;
    localparam logic [15:0] KEY_HI_B = 16'h0034;

    // bytes skipped after int, GUID and string tokens
    localparam logic [35:0] SKIP_INT    = 36'd4;
    localparam logic [35:0] SKIP_GUID   = 36'd16;
    localparam logic [35:0] SKIP_STRING = 36'd2;

    // characters
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

endpackage

### rtl/xfile_token_stream_splitter.sv
// Token splitter for model file bodies, one byte per transfer.
// Each result is registered into the result queue when the byte that causes
// it is taken; a text character is emitted when the following byte arrives.
// Throughput: one byte per cycle while the three-entry result queue holds at
// most one result after any pop; otherwise input stalls until results are taken.
// Reset (synchronous, active low): token state idle, registers to defaults.
module xfile_token_stream_splitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  xtss_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output xtss_pkg::t_out_item         o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [xtss_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import xtss_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ID_HI, PH_LEN_NAME, PH_LEN_STR, PH_LEN_INTS, PH_LEN_FLTS,
        PH_BODY_NAME, PH_BODY_STR, PH_SKIP
    } t_phase;

    localparam int QDEPTH = 3;

    // configuration
    logic       r_binary_mode;
    logic [3:0] r_float_bytes;

    // token state
    t_phase      r_phase,        n_phase;
    logic [7:0]  r_id_low,       n_id_low;
    logic [1:0]  r_cnt,          n_cnt;
    logic [31:0] r_len,          n_len;
    logic [35:0] r_skip,         n_skip;
    logic [7:0]  r_held_char,    n_held_char;
    logic        r_held_valid,   n_held_valid;
    logic        r_in_comment,   n_in_comment;
    logic        r_slash_seen,   n_slash_seen;

    // result queue, head at entry 0
    t_out_item   r_q [QDEPTH];
    t_out_item   n_q [QDEPTH];
    logic [1:0]  r_count, n_count;

    logic        cfg_we;
    logic        pop;
    logic        in_acc;
    logic [1:0]  base;
    t_out_item   res0, res1;
    logic [1:0]  nres;

    function automatic t_out_item mk(t_kind k, logic [7:0] b, logic e, logic z);
        t_out_item r;
        r.kind        = k;
        r.token_byte  = b;
        r.token_end   = e;
        r.token_empty = z;
        return r;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_FLOAT_BYTES) ? {28'd0, r_float_bytes}
                                                  : {31'd0, r_binary_mode};

    // handshakes
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_item  = r_q[0];
    assign pop         = o_out_valid && i_out_ready;
    assign base        = r_count - {1'b0, pop};
    assign o_in_ready  = (base <= 2'd1);
    assign in_acc      = i_in_valid && o_in_ready;

    // token step
    always_comb begin
        logic [7:0]  b;
        logic [15:0] id16;
        logic [31:0] len_full;
        logic [35:0] skip_len;
        logic        hv;
        logic [7:0]  hc;
        logic        go;

        b        = i_in_item.data_byte;
        id16     = {b, r_id_low};
        len_full = r_len | ({24'd0, b} << {r_cnt, 3'b000});
        skip_len = 36'(len_full) * 36'(r_float_bytes);
        hv       = r_held_valid;
        hc       = r_held_char;
        go       = 1'b1;

        n_phase      = r_phase;
        n_id_low     = r_id_low;
        n_cnt        = r_cnt;
        n_len        = r_len;
        n_skip       = r_skip;
        n_held_char  = r_held_char;
        n_held_valid = r_held_valid;
        n_in_comment = r_in_comment;
        n_slash_seen = r_slash_seen;
        res0         = '0;
        res1         = '0;
        nres         = 2'd0;

        if (in_acc) begin
            if (i_in_item.is_end) begin
                // flush pending token, then clear
                if (r_binary_mode) begin
                    if (r_phase inside {PH_LEN_NAME, PH_LEN_STR, PH_LEN_INTS,
                                        PH_LEN_FLTS, PH_BODY_NAME, PH_BODY_STR}) begin
                        res0 = mk(KIND_TRUNC, 8'd0, 1'b1, 1'b0);
                        nres = 2'd1;
                    end
                end else if (r_slash_seen) begin
                    res0 = mk(KIND_TEXT, CH_SLASH, 1'b1, 1'b0);
                    nres = 2'd1;
                end else if (r_held_valid) begin
                    res0 = mk(KIND_TEXT, r_held_char, 1'b1, 1'b0);
                    nres = 2'd1;
                end
                n_phase      = PH_IDLE;
                n_id_low     = '0;
                n_cnt        = '0;
                n_len        = '0;
                n_skip       = '0;
                n_held_char  = '0;
                n_held_valid = 1'b0;
                n_in_comment = 1'b0;
                n_slash_seen = 1'b0;
            end else if (r_binary_mode) begin
                case (r_phase)
                    PH_IDLE: begin
                        n_id_low = b;
                        n_phase  = PH_ID_HI;
                    end
                    PH_ID_HI: begin
                        n_len = '0;
                        n_cnt = '0;
                        n_phase = PH_IDLE;
                        if (id16 == ID_NAME) begin
                            n_phase = PH_LEN_NAME;
                        end else if (id16 == ID_STRING) begin
                            n_phase = PH_LEN_STR;
                        end else if (id16 == ID_INTLIST) begin
                            n_phase = PH_LEN_INTS;
                        end else if (id16 == ID_FLTLIST) begin
                            n_phase = PH_LEN_FLTS;
                        end else if (id16 == ID_INT) begin
                            res0    = mk(KIND_INT, 8'd0, 1'b1, 1'b0);
                            nres    = 2'd1;
                            n_skip  = SKIP_INT;
                            n_phase = PH_SKIP;
                        end else if (id16 == ID_GUID) begin
                            res0    = mk(KIND_GUID, 8'd0, 1'b1, 1'b0);
                            nres    = 2'd1;
                            n_skip  = SKIP_GUID;
                            n_phase = PH_SKIP;
                        end else if (id16 inside {[KEY_LO_A:KEY_HI_A], KEY_MID,
                                                  [KEY_LO_B:KEY_HI_B]}) begin
                            res0 = mk(KIND_KEY, id16[7:0], 1'b1, 1'b0);
                            nres = 2'd1;
                        end else begin
                            res0 = mk(KIND_UNK, id16[7:0], 1'b1, 1'b0);
                            nres = 2'd1;
                        end
                    end
                    PH_LEN_NAME, PH_LEN_STR, PH_LEN_INTS, PH_LEN_FLTS: begin
                        n_len = len_full;
                        n_cnt = r_cnt + 2'd1;
                        if (r_cnt == 2'd3) begin
                            // length word complete
                            case (r_phase)
                                PH_LEN_INTS: begin
                                    res0    = mk(KIND_INTS, 8'd0, 1'b1, 1'b0);
                                    nres    = 2'd1;
                                    n_skip  = {2'd0, len_full, 2'd0};
                                    n_phase = (len_full == 32'd0) ? PH_IDLE : PH_SKIP;
                                end
                                PH_LEN_FLTS: begin
                                    res0    = mk(KIND_FLTS, 8'd0, 1'b1, 1'b0);
                                    nres    = 2'd1;
                                    n_skip  = skip_len;
                                    n_phase = (skip_len == 36'd0) ? PH_IDLE : PH_SKIP;
                                end
                                PH_LEN_NAME: begin
                                    if (len_full == 32'd0) begin
                                        res0    = mk(KIND_NAME, 8'd0, 1'b1, 1'b1);
                                        nres    = 2'd1;
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_phase = PH_BODY_NAME;
                                    end
                                end
                                default: begin
                                    if (len_full == 32'd0) begin
                                        res0    = mk(KIND_STRING, 8'd0, 1'b1, 1'b1);
                                        nres    = 2'd1;
                                        n_skip  = SKIP_STRING;
                                        n_phase = PH_SKIP;
                                    end else begin
                                        n_phase = PH_BODY_STR;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_BODY_NAME, PH_BODY_STR: begin
                        res0  = mk((r_phase == PH_BODY_NAME) ? KIND_NAME : KIND_STRING,
                                   b, r_len == 32'd1, 1'b0);
                        nres  = 2'd1;
                        n_len = r_len - 32'd1;
                        if (r_len == 32'd1) begin
                            if (r_phase == PH_BODY_NAME) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_skip  = SKIP_STRING;
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_skip = r_skip - 36'd1;
                        if (r_skip == 36'd1) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end else if (r_in_comment) begin
                // comment runs to end of line
                if (b == CH_LF || b == CH_CR) begin
                    n_in_comment = 1'b0;
                end
            end else begin
                // a pending slash either opens a comment or starts a word
                if (r_slash_seen) begin
                    n_slash_seen = 1'b0;
                    if (b == CH_SLASH) begin
                        n_in_comment = 1'b1;
                        go           = 1'b0;
                    end else begin
                        hc = CH_SLASH;
                        hv = 1'b1;
                    end
                end
                if (go) begin
                    if (hv) begin
                        if (b inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
                            res0         = mk(KIND_TEXT, hc, 1'b1, 1'b0);
                            nres         = 2'd1;
                            n_held_valid = 1'b0;
                        end else if (b inside {CH_SEMI, CH_COMMA, CH_LBRACE,
                                               CH_RBRACE}) begin
                            res0         = mk(KIND_TEXT, hc, 1'b1, 1'b0);
                            res1         = mk(KIND_TEXT, b, 1'b1, 1'b0);
                            nres         = 2'd2;
                            n_held_valid = 1'b0;
                        end else begin
                            res0         = mk(KIND_TEXT, hc, 1'b0, 1'b0);
                            nres         = 2'd1;
                            n_held_char  = b;
                            n_held_valid = 1'b1;
                        end
                    end else if (b inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
                        n_held_valid = 1'b0;
                    end else if (b inside {CH_SEMI, CH_COMMA, CH_LBRACE,
                                           CH_RBRACE}) begin
                        res0 = mk(KIND_TEXT, b, 1'b1, 1'b0);
                        nres = 2'd1;
                    end else if (b == CH_HASH) begin
                        n_in_comment = 1'b1;
                    end else if (b == CH_SLASH) begin
                        n_slash_seen = 1'b1;
                    end else begin
                        n_held_char  = b;
                        n_held_valid = 1'b1;
                    end
                end
            end
        end
    end

    // result queue: shift on pop, append up to two results
    always_comb begin
        for (int i = 0; i < QDEPTH - 1; i++) begin
            n_q[i] = pop ? r_q[i + 1] : r_q[i];
        end
        n_q[QDEPTH - 1] = r_q[QDEPTH - 1];
        for (int i = 0; i < QDEPTH; i++) begin
            if (nres != 2'd0 && 2'(i) == base) begin
                n_q[i] = res0;
            end
            if (nres == 2'd2 && 2'(i) == base + 2'd1) begin
                n_q[i] = res1;
            end
        end
        n_count = base + nres;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_mode <= 1'b0;
            r_float_bytes <= FLOAT_BYTES_RST;
            r_phase       <= PH_IDLE;
            r_id_low      <= '0;
            r_cnt         <= '0;
            r_len         <= '0;
            r_skip        <= '0;
            r_held_char   <= '0;
            r_held_valid  <= 1'b0;
            r_in_comment  <= 1'b0;
            r_slash_seen  <= 1'b0;
            r_count       <= '0;
        end else begin
            r_q          <= n_q;
            r_count      <= n_count;
            r_phase      <= n_phase;
            r_id_low     <= n_id_low;
            r_cnt        <= n_cnt;
            r_len        <= n_len;
            r_skip       <= n_skip;
            r_held_char  <= n_held_char;
            r_held_valid <= n_held_valid;
            r_in_comment <= n_in_comment;
            r_slash_seen <= n_slash_seen;
            if (cfg_we) begin
                if (paddr[2] == REG_BINARY_MODE) begin
                    // mode change drops any partial token
                    r_binary_mode <= pwdata[0];
                    r_phase       <= PH_IDLE;
                    r_id_low      <= '0;
                    r_cnt         <= '0;
                    r_len         <= '0;
                    r_skip        <= '0;
                    r_held_char   <= '0;
                    r_held_valid  <= 1'b0;
                    r_in_comment  <= 1'b0;
                    r_slash_seen  <= 1'b0;
                end else begin
                    r_float_bytes <= pwdata[3:0];
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");
    a_slash_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_slash_seen && r_held_valid))
        else $error("pending slash alongside held character");
    a_comment_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_comment |-> !r_held_valid && !r_slash_seen)
        else $error("comment with pending word state");
    a_binary_text_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_binary_mode |-> !r_held_valid && !r_in_comment && !r_slash_seen)
        else $error("text state active in binary mode");
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip != 36'd0))
        else $error("skip phase with nothing to skip");
`endif

endmodule
